@@ hw/rtl/polygon_point_coverage_test_core_defines.svh @@
// ----------------------------------------------------------------------------
// Polygon point coverage test: assertion macros
// Shared concurrent assertion forms used by the coverage test RTL.
// ----------------------------------------------------------------------------
`ifndef POLYGON_POINT_COVERAGE_TEST_CORE_DEFINES_SVH
`define POLYGON_POINT_COVERAGE_TEST_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PPCT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PPCT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ppct_pkg.sv @@
// ----------------------------------------------------------------------------
// Polygon point coverage test: shared package
// Sizes, field types, action and register codes, and the edge request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ppct_pkg;

    // Polygon capacity and coordinate width
    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);

    // Edge arithmetic widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // Other field widths
    localparam int COLOR_W  = 32;
    localparam int FRAME_W  = 13;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W = 1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS     = 2 * COORD_BITS + COLOR_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * COORD_BITS + 3 + COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_BEGIN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TEST   = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [FRAME_W-1:0]   FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0]   FRAME_HEIGHT_RST = 13'd480;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_vertex;

    // One edge handed to the crossing unit: vertex i and previous vertex j
    typedef struct packed {
        logic    vld;
        t_vertex vi;
        t_vertex vj;
    } t_edge_req;

endpackage

`default_nettype wire

@@ hw/rtl/ppct_vtx_ram.sv @@
// ----------------------------------------------------------------------------
// Polygon point coverage test: vertex store
// One write port and one registered read port over the polygon vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module ppct_vtx_ram
    import ppct_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_we,
    input  wire [VIDX_W-1:0]   i_waddr,
    input  t_vertex            i_wdata,
    input  wire [VIDX_W-1:0]   i_raddr,
    output t_vertex            o_rdata
);

    t_vertex r_mem [MAX_VERTICES];
    t_vertex r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/ppct_edge_unit.sv @@
// ----------------------------------------------------------------------------
// Polygon point coverage test: edge crossing unit
// Two-register pipeline taking one edge per cycle; the toggle for an edge is
// valid once the edge has passed stage A and stage B, and says whether the edge
// crosses the test row strictly left of the test column, exact by
// cross-multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module ppct_edge_unit
    import ppct_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_edge_req  i_req,
    input  t_coord     i_tx,
    input  t_coord     i_ty,
    output logic       o_toggle
);

    // Stage A: straddle check and coordinate differences
    logic  w_straddle;
    logic  w_left;
    logic  r_a_vld;
    logic  r_a_hit;
    t_diff r_a_dyt;
    t_diff r_a_dx;
    t_diff r_a_dxt;
    t_diff r_a_dy;

    // Stage B: products
    logic  r_b_vld;
    logic  r_b_hit;
    logic  r_b_dpos;
    t_prod r_b_lhs;
    t_prod r_b_rhs;

    assign w_straddle = ((i_req.vi.y < i_ty) && (i_req.vj.y >= i_ty)) ||
                        ((i_req.vj.y < i_ty) && (i_req.vi.y >= i_ty));
    assign w_left     = (i_req.vi.x <= i_tx) || (i_req.vj.x <= i_tx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_req.vld;
            r_b_vld <= r_a_vld;
        end
    end

    // Payload of both stages
    always_ff @(posedge i_clk) begin
        r_a_hit  <= w_straddle && w_left;
        r_a_dyt  <= $signed({i_ty[COORD_BITS-1], i_ty}) -
                    $signed({i_req.vi.y[COORD_BITS-1], i_req.vi.y});
        r_a_dx   <= $signed({i_req.vj.x[COORD_BITS-1], i_req.vj.x}) -
                    $signed({i_req.vi.x[COORD_BITS-1], i_req.vi.x});
        r_a_dxt  <= $signed({i_tx[COORD_BITS-1], i_tx}) -
                    $signed({i_req.vi.x[COORD_BITS-1], i_req.vi.x});
        r_a_dy   <= $signed({i_req.vj.y[COORD_BITS-1], i_req.vj.y}) -
                    $signed({i_req.vi.y[COORD_BITS-1], i_req.vi.y});

        r_b_hit  <= r_a_hit;
        r_b_dpos <= !r_a_dy[DIFF_W-1] && (r_a_dy != '0);
        r_b_lhs  <= r_a_dyt * r_a_dx;
        r_b_rhs  <= r_a_dxt * r_a_dy;
    end

    // Compare with the sign of the edge's dy folded in
    assign o_toggle = r_b_vld && r_b_hit &&
                      (r_b_dpos ? (r_b_lhs < r_b_rhs) : (r_b_lhs > r_b_rhs));

endmodule

`default_nettype wire

@@ hw/rtl/polygon_point_coverage_test_core.sv @@
// Test beat: the edge walk reads the vertex store one entry per cycle, the last vertex
// first and then each vertex in order (skipped when empty); then the crossing unit drains
// and a finish state loads the result register. The finish state stretches while the
// result register holds an unaccepted beat. The next beat can be taken in the cycle after
// the result loads. Begin and append beats leave the core idle; reset clears the sequencer
// and polygon state, frame is 640x480.
// ----------------------------------------------------------------------------
// Polygon point coverage test core
// Even-odd point-in-polygon test with bounding box and frame clip; vertices
// are walked one edge per cycle through a shared crossing unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_point_coverage_test_core_defines.svh"

module polygon_point_coverage_test_core
    import ppct_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Input stream
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   i_s_axis_tdata,   // coord_x, coord_y, color_in
    input  wire [ACTION_W-1:0]     i_s_axis_tuser,   // action
    // Output stream
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // pixel_x, pixel_y, covered,
                                                     // in_frame, write_enable,
                                                     // pixel_color, zero pad
    // Configuration
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [FRAME_W-1:0]      i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [1:0]          r_state;
    logic [VCNT_W-1:0]   r_vcount;
    logic [VCNT_W-1:0]   r_rd_cnt;
    logic [1:0]          r_drain_cnt;
    logic                r_rd_vld;
    logic                r_rd_first;
    logic                r_parity;
    t_coord              r_box_min_x;
    t_coord              r_box_max_x;
    t_coord              r_box_min_y;
    t_coord              r_box_max_y;
    logic [COLOR_W-1:0]  r_fill_color;
    logic [FRAME_W-1:0]  r_frame_w;
    logic [FRAME_W-1:0]  r_frame_h;
    t_coord              r_tx;
    t_coord              r_ty;
    t_vertex             r_prev;

    logic                r_out_vld;
    t_coord              r_out_x;
    t_coord              r_out_y;
    logic                r_out_cov;
    logic                r_out_inf;
    logic [COLOR_W-1:0]  r_out_color;

    logic                w_in_acc;
    logic                w_out_load;
    logic [ACTION_W-1:0] w_action;
    t_vertex             w_in_vtx;
    logic [COLOR_W-1:0]  w_in_color;
    logic                w_vtx_we;
    logic [VCNT_W-1:0]   w_last;
    logic [VCNT_W-1:0]   w_cnt_m1;
    logic [VIDX_W-1:0]   n_rd_addr;
    t_vertex             w_rd_vtx;
    t_edge_req           w_edge;
    logic                w_toggle;
    logic                w_in_box;
    logic                w_in_frame;

    // Input beat fields
    assign w_action    = i_s_axis_tuser;
    assign w_in_vtx.x  = i_s_axis_tdata[COORD_BITS-1:0];
    assign w_in_vtx.y  = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_in_color  = i_s_axis_tdata[2*COORD_BITS+COLOR_W-1:2*COORD_BITS];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == ST_FINISH) && (!r_out_vld || i_m_axis_tready);

    // Vertex store write on an append within capacity
    assign w_vtx_we = w_in_acc && (w_action == ACT_APPEND) &&
                      (r_vcount < VCNT_W'(MAX_VERTICES));

    // Walk order: last vertex first, then 0 .. n-1
    assign w_last    = r_vcount - VCNT_W'(1);
    assign w_cnt_m1  = r_rd_cnt - VCNT_W'(1);
    assign n_rd_addr = (r_rd_cnt == '0) ? w_last[VIDX_W-1:0] : w_cnt_m1[VIDX_W-1:0];

    ppct_vtx_ram u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_vtx_we),
        .i_waddr (r_vcount[VIDX_W-1:0]),
        .i_wdata (w_in_vtx),
        .i_raddr (n_rd_addr),
        .o_rdata (w_rd_vtx)
    );

    // Edge request: fresh vertex i with the one read before it
    assign w_edge.vld = r_rd_vld && !r_rd_first;
    assign w_edge.vi  = w_rd_vtx;
    assign w_edge.vj  = r_prev;

    ppct_edge_unit u_edge_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_edge),
        .i_tx     (r_tx),
        .i_ty     (r_ty),
        .o_toggle (w_toggle)
    );

    // Sequencer and polygon state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_vcount     <= '0;
            r_rd_cnt     <= '0;
            r_drain_cnt  <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_first   <= 1'b0;
            r_parity     <= 1'b0;
            r_box_min_x  <= '0;
            r_box_max_x  <= '0;
            r_box_min_y  <= '0;
            r_box_max_y  <= '0;
            r_fill_color <= '0;
        end else begin
            r_rd_vld   <= (r_state == ST_WALK);
            r_rd_first <= (r_state == ST_WALK) && (r_rd_cnt == '0);
            if (w_toggle) begin
                r_parity <= ~r_parity;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (w_action == ACT_BEGIN) begin
                            r_vcount     <= '0;
                            r_box_min_x  <= '0;
                            r_box_max_x  <= '0;
                            r_box_min_y  <= '0;
                            r_box_max_y  <= '0;
                            r_fill_color <= w_in_color;
                        end else if (w_vtx_we) begin
                            r_vcount <= r_vcount + VCNT_W'(1);
                            if (r_vcount == '0) begin
                                r_box_min_x <= w_in_vtx.x;
                                r_box_max_x <= w_in_vtx.x;
                                r_box_min_y <= w_in_vtx.y;
                                r_box_max_y <= w_in_vtx.y;
                            end else begin
                                if (w_in_vtx.x < r_box_min_x) r_box_min_x <= w_in_vtx.x;
                                if (w_in_vtx.x > r_box_max_x) r_box_max_x <= w_in_vtx.x;
                                if (w_in_vtx.y < r_box_min_y) r_box_min_y <= w_in_vtx.y;
                                if (w_in_vtx.y > r_box_max_y) r_box_max_y <= w_in_vtx.y;
                            end
                        end else if (w_action == ACT_TEST) begin
                            r_parity    <= 1'b0;
                            r_rd_cnt    <= '0;
                            r_drain_cnt <= '0;
                            r_state     <= (r_vcount == '0) ? ST_DRAIN : ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    r_rd_cnt <= r_rd_cnt + VCNT_W'(1);
                    if (r_rd_cnt == r_vcount) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_drain_cnt <= r_drain_cnt + 2'd1;
                    if (r_drain_cnt == DRAIN_LAST) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Test point capture and previous vertex
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_action == ACT_TEST)) begin
            r_tx <= w_in_vtx.x;
            r_ty <= w_in_vtx.y;
        end
        if (r_rd_vld) begin
            r_prev <= w_rd_vtx;
        end
    end

    // Frame size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_WIDTH_RST;
            r_frame_h <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_wdata;
                default:          r_frame_w <= r_frame_w;
            endcase
        end
    end

    // Half-open box and frame clip
    assign w_in_box   = (r_tx >= r_box_min_x) && (r_tx < r_box_max_x) &&
                        (r_ty >= r_box_min_y) && (r_ty < r_box_max_y);
    assign w_in_frame = !r_tx[COORD_BITS-1] && !r_ty[COORD_BITS-1] &&
                        ($unsigned(r_tx) < r_frame_w) && ($unsigned(r_ty) < r_frame_h);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_x     <= r_tx;
            r_out_y     <= r_ty;
            r_out_cov   <= r_parity && w_in_box;
            r_out_inf   <= w_in_frame;
            r_out_color <= r_fill_color;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_color, r_out_cov && r_out_inf,
                                           r_out_inf, r_out_cov, r_out_y, r_out_x});

    // Checks
    `PPCT_ASSERT_IMP(a_vcount_cap, i_clk, i_rst_n, 1'b1,
        r_vcount <= VCNT_W'(MAX_VERTICES), "vertex count above capacity")
    `PPCT_ASSERT_IMP(a_walk_range, i_clk, i_rst_n, r_state == ST_WALK,
        r_rd_cnt <= r_vcount, "edge walk ran past the vertex count")
    `PPCT_ASSERT_NXT(a_test_starts, i_clk, i_rst_n,
        w_in_acc && (w_action == ACT_TEST),
        (r_state == ST_WALK) || (r_state == ST_DRAIN), "test beat did not start a walk")
    `PPCT_ASSERT_IMP(a_no_toggle_idle, i_clk, i_rst_n, r_state == ST_IDLE,
        !w_toggle, "crossing reported outside a walk")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Polygon point coverage test: stream-level testbench
// Builds polygons one vertex beat at a time and sends pixel tests against
// them. A local even-odd predictor computes the expected coverage, frame
// clip and write enable, and the monitor checks every result beat in order.
// Both stream sides idle at random, and the result side holds off twice for
// a long stretch so the core backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ppct_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        t_coord              x;
        t_coord              y;
        logic [COLOR_W-1:0]  color;
    } cmd_beat_t;

    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic               covered;
        logic               in_frame;
        logic               write_en;
        logic [COLOR_W-1:0] color;
    } pix_result_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Core ports
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [ACTION_W-1:0]    s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [FRAME_W-1:0]     cfg_wdata = '0;

    polygon_point_coverage_test_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Stimulus and expectation stores
    cmd_beat_t   cmd_pending[$];
    pix_result_t pix_expect[$];

    // Predictor state
    int             poly_x[MAX_VERTICES];
    int             poly_y[MAX_VERTICES];
    int             n_vert  = 0;
    int             box_x0  = 0;
    int             box_x1  = 0;
    int             box_y0  = 0;
    int             box_y1  = 0;
    logic [31:0]    fill_rgb = '0;
    int             frame_w = FRAME_WIDTH_RST;
    int             frame_h = FRAME_HEIGHT_RST;

    // Handshake flags seen at the last rising edge
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;

    // Bookkeeping
    int fails = 0;
    int cycles = 0;
    int n_begin = 0, n_append = 0, n_test = 0, n_ignored = 0;
    int n_covered = 0, n_written = 0, n_frames = 0, n_holds = 0;

    // Idle control
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Edge (xi,yi)-(xj,yj) crosses row ty strictly left of column tx
    function automatic bit edge_flips(int xi, int yi, int xj, int yj, int tx, int ty);
        longint d, lhs, rhs;
        bit     straddle;
        straddle = (yi < ty && yj >= ty) || (yj < ty && yi >= ty);
        if (!straddle || !(xi <= tx || xj <= tx))
            return 1'b0;
        d   = longint'(yj) - longint'(yi);
        lhs = (longint'(ty) - longint'(yi)) * (longint'(xj) - longint'(xi));
        rhs = (longint'(tx) - longint'(xi)) * d;
        return (d > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    task automatic predict_beat(input cmd_beat_t c);
        pix_result_t r;
        bit          odd;
        bit          in_box;
        int          cx, cy, i, j;
        cx = $signed(c.x);
        cy = $signed(c.y);
        case (c.act)
            ACT_BEGIN: begin
                n_vert = 0;
                box_x0 = 0; box_x1 = 0; box_y0 = 0; box_y1 = 0;
                fill_rgb = c.color;
                n_begin++;
            end
            ACT_APPEND: begin
                n_append++;
                if (n_vert < MAX_VERTICES) begin
                    poly_x[n_vert] = cx;
                    poly_y[n_vert] = cy;
                    if (n_vert == 0) begin
                        box_x0 = cx; box_x1 = cx; box_y0 = cy; box_y1 = cy;
                    end else begin
                        if (cx < box_x0) box_x0 = cx;
                        if (cx > box_x1) box_x1 = cx;
                        if (cy < box_y0) box_y0 = cy;
                        if (cy > box_y1) box_y1 = cy;
                    end
                    n_vert++;
                end
            end
            ACT_TEST: begin
                odd = 1'b0;
                j = n_vert - 1;
                for (i = 0; i < n_vert; i++) begin
                    if (edge_flips(poly_x[i], poly_y[i], poly_x[j], poly_y[j], cx, cy))
                        odd = !odd;
                    j = i;
                end
                in_box = cx >= box_x0 && cx < box_x1 && cy >= box_y0 && cy < box_y1;
                r.x        = c.x;
                r.y        = c.y;
                r.covered  = odd && in_box;
                r.in_frame = cx >= 0 && cy >= 0 && cx < frame_w && cy < frame_h;
                r.write_en = r.covered && r.in_frame;
                r.color    = fill_rgb;
                pix_expect.push_back(r);
                n_test++;
                if (r.covered) n_covered++;
                if (r.write_en) n_written++;
            end
            default: n_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        fails++;
        $display("MISMATCH @%0d: %s", cycles, msg);
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
        pix_result_t got, exp;
        got.x        = d[15:0];
        got.y        = d[31:16];
        got.covered  = d[32];
        got.in_frame = d[33];
        got.write_en = d[34];
        got.color    = d[66:35];
        if (pix_expect.size() == 0) begin
            flag_mismatch($sformatf("unexpected result beat x=%0d y=%0d",
                                    $signed(got.x), $signed(got.y)));
        end else begin
            exp = pix_expect.pop_front();
            if (got.x !== exp.x)
                flag_mismatch($sformatf("pixel_x %0d, want %0d", $signed(got.x), $signed(exp.x)));
            if (got.y !== exp.y)
                flag_mismatch($sformatf("pixel_y %0d, want %0d", $signed(got.y), $signed(exp.y)));
            if (got.covered !== exp.covered)
                flag_mismatch($sformatf("covered %b, want %b at (%0d,%0d)", got.covered,
                                        exp.covered, $signed(exp.x), $signed(exp.y)));
            if (got.in_frame !== exp.in_frame)
                flag_mismatch($sformatf("in_frame %b, want %b at (%0d,%0d)", got.in_frame,
                                        exp.in_frame, $signed(exp.x), $signed(exp.y)));
            if (got.write_en !== exp.write_en)
                flag_mismatch($sformatf("write_enable %b, want %b at (%0d,%0d)", got.write_en,
                                        exp.write_en, $signed(exp.x), $signed(exp.y)));
            if (got.color !== exp.color)
                flag_mismatch($sformatf("pixel_color %h, want %h", got.color, exp.color));
        end
    endtask

    // Monitor: both handshakes sampled at the rising edge
    always @(posedge clk) begin
        in_taken  = 1'b0;
        out_taken = 1'b0;
        cycles++;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                predict_beat(cmd_beat_t'{s_tuser, s_tdata[15:0], s_tdata[31:16],
                                         s_tdata[63:32]});
            end
            if (m_tvalid && m_tready) begin
                out_taken = 1'b1;
                check_result(m_tdata);
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycles,
                     pix_expect.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: next beat from the pending queue, random gap after each
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        cmd_beat_t nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cmd_pending.size() != 0) begin
                nxt = cmd_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.color, nxt.y, nxt.x};
                s_tuser  <= nxt.act;
                gap_left = tx_quiet ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 59) == 0) tx_quiet = !tx_quiet;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: short random stall after each result beat
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                stall_left = rx_quiet ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long hold-off on the result side, twice in the run
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((n_holds == 0 && n_test >= 100) || (n_holds == 1 && n_test >= 300)) begin
            hold_left <= HOLD_CYCLES;
            n_holds++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_cmd(input logic [ACTION_W-1:0] act, input int x, input int y,
                            input logic [31:0] color);
        cmd_pending.push_back(cmd_beat_t'{act, t_coord'(x), t_coord'(y), color});
    endtask

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Wait until everything sent has been answered and the core is quiet
    task automatic wait_idle();
        while (cmd_pending.size() != 0 || s_tvalid || pix_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_FRAME_WIDTH;
        cfg_wdata <= FRAME_W'(w);
        @(negedge clk);
        cfg_idx   <= CFG_FRAME_HEIGHT;
        cfg_wdata <= FRAME_W'(h);
        @(negedge clk);
        cfg_we    <= 1'b0;
        frame_w = w;
        frame_h = h;
        n_frames++;
    endtask

    // Polygon runs: begin, a handful of vertices, then pixel tests
    task automatic queue_runs(input int goal);
        int made, nv, nt, k, lo, hi, px, py, r;
        int vx[$];
        int vy[$];
        made = 0;
        while (made < goal) begin
            case ($urandom_range(0, 9))
                0, 1:    begin lo = -32768; hi = 32767; end
                2, 3:    begin lo = 0;      hi = 15;    end
                default: begin lo = -40;    hi = 720;   end
            endcase
            if ($urandom_range(0, 29) == 0)
                push_cmd(ACT_IGNORED, rand_in(-32768, 32767), rand_in(-32768, 32767),
                         $urandom());
            // now and then keep the old polygon and append to it
            if ($urandom_range(0, 19) != 0) begin
                push_cmd(ACT_BEGIN, rand_in(-32768, 32767), rand_in(-32768, 32767),
                         $urandom());
                made++;
            end
            r = $urandom_range(0, 9);
            if (r == 0)      nv = $urandom_range(0, 2);
            else if (r == 1) nv = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4);
            else             nv = $urandom_range(3, MAX_VERTICES);
            vx.delete();
            vy.delete();
            for (k = 0; k < nv; k++) begin
                px = rand_in(lo, hi);
                py = rand_in(lo, hi);
                vx.push_back(px);
                vy.push_back(py);
                push_cmd(ACT_APPEND, px, py, $urandom());
                made++;
            end
            nt = $urandom_range(1, 8);
            for (k = 0; k < nt; k++) begin
                r = $urandom_range(0, 9);
                if (r < 2 && vx.size() != 0) begin
                    px = vx[$urandom_range(0, vx.size() - 1)];
                    py = vy[$urandom_range(0, vy.size() - 1)];
                end else if (r == 2) begin
                    px = rand_in(-32768, 32767);
                    py = rand_in(-32768, 32767);
                end else begin
                    px = rand_in(lo, hi);
                    py = rand_in(lo, hi);
                end
                push_cmd(ACT_TEST, px, py, $urandom());
                made++;
            end
        end
    endtask

    initial begin
        int ph;
        int fw[6];
        int fh[6];
        fw = '{1, 4096, 640, 0, 4096, 0};
        fh = '{1, 4096, 480, 0, 1, 0};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty polygon, ignored code, square, degenerate, huge triangle
        push_cmd(ACT_TEST, 0, 0, '0);
        push_cmd(ACT_IGNORED, -1, -1, 32'hFFFF_FFFF);
        push_cmd(ACT_TEST, 32767, -32768, '0);
        push_cmd(ACT_BEGIN, 0, 0, 32'hFFFF_FFFF);
        push_cmd(ACT_APPEND, 10, 10, '0);
        push_cmd(ACT_APPEND, 100, 10, '0);
        push_cmd(ACT_APPEND, 100, 100, '0);
        push_cmd(ACT_APPEND, 10, 100, '0);
        push_cmd(ACT_TEST, 50, 50, '0);
        push_cmd(ACT_TEST, 10, 10, '0);
        push_cmd(ACT_TEST, 100, 50, '0);
        push_cmd(ACT_TEST, 99, 99, '0);
        push_cmd(ACT_TEST, 9, 50, '0);
        push_cmd(ACT_TEST, 50, 100, '0);
        push_cmd(ACT_BEGIN, -1, -1, 32'h0);
        push_cmd(ACT_APPEND, -32768, -32768, '0);
        push_cmd(ACT_TEST, -32768, -32768, '0);
        push_cmd(ACT_APPEND, 32767, -32768, '0);
        push_cmd(ACT_TEST, 0, -32768, '0);
        push_cmd(ACT_APPEND, 0, 32767, '0);
        push_cmd(ACT_TEST, 0, 0, '0);
        push_cmd(ACT_TEST, -100, -100, '0);
        push_cmd(ACT_TEST, 32767, 32767, '0);
        push_cmd(ACT_TEST, 639, 479, '0);
        push_cmd(ACT_TEST, 640, 0, '0);
        wait_idle();

        // Random phases, each under its own frame size
        for (ph = 0; ph < 6; ph++) begin
            set_frame(fw[ph] != 0 ? fw[ph] : rand_in(1, 4096),
                      fh[ph] != 0 ? fh[ph] : rand_in(1, 4096));
            queue_runs(PHASE_ITEMS);
            wait_idle();
        end

        while (pix_expect.size() != 0) begin
            flag_mismatch("result never arrived");
            void'(pix_expect.pop_front());
        end

        $display("Covered %0d begin, %0d append, %0d test and %0d ignored beats",
                 n_begin, n_append, n_test, n_ignored);
        $display("%0d pixels covered, %0d written, %0d frame sizes, %0d long hold-offs",
                 n_covered, n_written, n_frames, n_holds);
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
